FILE: design/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the small matrix multiplier modules.
// ----------------------------------------------------------------------------
package smm_pkg;

    // Function codes carried by an input transaction
    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    // Configuration register indexes (byte address 4 * index)
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;

    // Result indices are 2 bits wide, so no active dimension exceeds this
    localparam int IDX_CAP = 4;

    // 48-bit shifted products, up to four of them summed
    localparam int TERM_W = 48;
    localparam int ACC_W  = 50;

    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         row_index;
        logic [1:0]         col_index;
        logic signed [31:0] element_value;
    } smm_in_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [31:0] out_value;
        logic               last;
    } smm_out_t;

    // Command passed from the front end to the back end
    typedef struct packed {
        logic               compute;
        logic               sel_b;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
    } smm_cmd_t;

    // Active dimensions as seen by the back end
    typedef struct packed {
        logic [2:0] rows;
        logic [2:0] inner;
        logic [2:0] cols;
    } smm_dims_t;

    // Saturate the wide sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]))
        begin
            r = v[31:0];
        end
        else if (v[ACC_W-1])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: design/smm_front.sv
// ----------------------------------------------------------------------------
// smm_front
// Accepts input transactions, drops those without effect, queues commands.
// ----------------------------------------------------------------------------
module smm_front #(
    parameter int MAX_DIM = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  smm_pkg::smm_in_t  item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output smm_pkg::smm_cmd_t cmd
);
    import smm_pkg::*;

    localparam logic [3:0] MAX_DIM_W = 4'(MAX_DIM);

    smm_cmd_t   q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       keep;
    logic       is_load;
    logic       push;
    logic       pop;
    smm_cmd_t   new_cmd;

    // Classify: loads outside the store and unused codes are dropped
    always_comb
    begin
        is_load = (item.func == FUNC_LOAD_A) || (item.func == FUNC_LOAD_B);
        keep    = (item.func == FUNC_COMPUTE) ||
                  (is_load && ({2'b00, item.row_index} < MAX_DIM_W) &&
                   ({2'b00, item.col_index} < MAX_DIM_W));
        new_cmd.compute = (item.func == FUNC_COMPUTE);
        new_cmd.sel_b   = (item.func == FUNC_LOAD_B);
        new_cmd.row     = item.row_index;
        new_cmd.col     = item.col_index;
        new_cmd.value   = item.element_value;
    end

    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready && keep;
    assign cmd_valid  = (count_reg != 2'd0);
    assign pop        = cmd_valid && cmd_ready;
    assign cmd        = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

FILE: design/smm_back.sv
// ----------------------------------------------------------------------------
// smm_back
// Holds A and B, runs the multiply-accumulate sequence, drives the results.
// ----------------------------------------------------------------------------
module smm_back #(
    parameter int MAX_DIM = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  smm_pkg::smm_cmd_t  cmd,
    input  smm_pkg::smm_dims_t dims,
    output logic               result_valid,
    input  logic               result_ready,
    output smm_pkg::smm_out_t  result
);
    import smm_pkg::*;

    localparam int         DEPTH   = MAX_DIM * MAX_DIM;
    localparam int         AW      = $clog2(DEPTH);
    localparam logic [AW-1:0] MD   = AW'(MAX_DIM);
    localparam logic [2:0] DIM_LIM = 3'((MAX_DIM < IDX_CAP) ? MAX_DIM : IDX_CAP);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAC  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    logic signed [31:0] mem_a [DEPTH];
    logic signed [31:0] mem_b [DEPTH];

    state_t              state_reg;
    state_t              state_next;
    logic [1:0]          i_reg, i_next;
    logic [1:0]          j_reg, j_next;
    logic [1:0]          k_reg, k_next;
    logic                rd_vld_reg;
    logic                prod_vld_reg;
    logic signed [31:0]  a_rd_reg;
    logic signed [31:0]  b_rd_reg;
    logic signed [63:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                out_vld_reg;
    logic                out_vld_next;
    smm_out_t            out_reg;
    smm_out_t            out_next;

    logic [1:0]          i_last, j_last, k_last;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       a_addr;
    logic [AW-1:0]       b_addr;
    logic                wr_a, wr_b;
    logic                slot_free;
    logic                pipe_empty;
    logic                emit;
    logic                acc_clear;
    logic signed [TERM_W-1:0] term;

    function automatic logic [1:0] last_idx(input logic [2:0] d);
        logic [2:0] c;
        if (d == 3'd0)
        begin
            c = 3'd1;
        end
        else if (d > DIM_LIM)
        begin
            c = DIM_LIM;
        end
        else
        begin
            c = d;
        end
        return 2'(c - 3'd1);
    endfunction

    assign i_last = last_idx(dims.rows);
    assign j_last = last_idx(dims.cols);
    assign k_last = last_idx(dims.inner);

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign slot_free  = !out_vld_reg || result_ready;
    assign pipe_empty = !rd_vld_reg && !prod_vld_reg;
    assign emit       = (state_reg == ST_EMIT) && pipe_empty && slot_free;

    assign wr_addr = AW'(cmd.row) * MD + AW'(cmd.col);
    assign a_addr  = AW'(i_reg) * MD + AW'(k_reg);
    assign b_addr  = AW'(k_reg) * MD + AW'(j_reg);
    assign wr_a    = cmd_valid && cmd_ready && !cmd.compute && !cmd.sel_b;
    assign wr_b    = cmd_valid && cmd_ready && !cmd.compute && cmd.sel_b;

    // Sequencer over result elements and inner terms
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        acc_clear  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.compute)
                begin
                    i_next     = 2'd0;
                    j_next     = 2'd0;
                    k_next     = 2'd0;
                    acc_clear  = 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == k_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    k_next    = 2'd0;
                    acc_clear = 1'b1;
                    if (j_reg == j_last)
                    begin
                        j_next = 2'd0;
                        if (i_reg == i_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 2'd1;
                            state_next = ST_MAC;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Floor shift by 16 is the top bits of the product
    assign term = prod_reg[63:16];

    always_comb
    begin
        if (acc_clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(term);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg && !result_ready;
        out_next     = out_reg;
        if (emit)
        begin
            out_vld_next      = 1'b1;
            out_next.out_row   = i_reg;
            out_next.out_col   = j_reg;
            out_next.out_value = sat32(acc_reg);
            out_next.last      = (i_reg == i_last) && (j_reg == j_last);
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= 2'd0;
            j_reg        <= 2'd0;
            k_reg        <= 2'd0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            rd_vld_reg   <= (state_reg == ST_MAC);
            prod_vld_reg <= rd_vld_reg;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Datapath: registered reads, product, accumulate
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= cmd.value;
        end
        if (wr_b)
        begin
            mem_b[wr_addr] <= cmd.value;
        end
        a_rd_reg <= mem_a[a_addr];
        b_rd_reg <= mem_b[b_addr];
        prod_reg <= 64'(a_rd_reg) * 64'(b_rd_reg);
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

endmodule

FILE: design/small_matrix_multiply.sv
// ----------------------------------------------------------------------------
// small_matrix_multiply: C = A x B in signed Q16.16, up to 4 x 4 active.
// Loads are queued while there is room; the back end writes A or B from the queue
// when idle, otherwise once the running compute has emitted its last element.
// Compute: each element of C is built from a registered memory read per term,
// a multiply stage and an accumulate stage, then placed in the result register.
// Reset: asynchronous, active low; dimensions return to 4, A and B hold stale data.
// ----------------------------------------------------------------------------
module small_matrix_multiply #(
    parameter int MAX_DIM = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    // input transactions
    input  logic              item_valid,
    output logic              item_ready,
    input  smm_pkg::smm_in_t  item,
    // result transactions
    output logic              result_valid,
    input  logic              result_ready,
    output smm_pkg::smm_out_t result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import smm_pkg::*;

    logic       cmd_valid;
    logic       cmd_ready;
    smm_cmd_t   cmd;
    smm_dims_t  dims;
    logic [2:0] rows_reg,  rows_next;
    logic [2:0] inner_reg, inner_next;
    logic [2:0] cols_reg,  cols_next;
    logic       cfg_wr;

    // Register file: one 3-bit field per word, written in the access phase.
    // Writes must arrive only while idle, which the block leaves to the user; the back end reads them live.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ROWS:  rows_next  = pwdata[2:0];
                REG_INNER: inner_next = pwdata[2:0];
                REG_COLS:  cols_next  = pwdata[2:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROWS:  prdata = {29'd0, rows_reg};
            REG_INNER: prdata = {29'd0, inner_reg};
            REG_COLS:  prdata = {29'd0, cols_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= 3'd4;
            inner_reg <= 3'd4;
            cols_reg  <= 3'd4;
        end
        else
        begin
            rows_reg  <= rows_next;
            inner_reg <= inner_next;
            cols_reg  <= cols_next;
        end
    end

    assign dims.rows  = rows_reg;
    assign dims.inner = inner_reg;
    assign dims.cols  = cols_reg;

    // Front end: classify and queue; drop transactions that have no effect
    smm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // Back end: stores, multiply-accumulate sequencer, result register
    smm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .dims         (dims),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for small_matrix_multiply
// Loads elements of A and B, sets the active dimensions over the register
// port and issues compute transactions. Every emitted element of C is
// checked against a matrix product kept in the bench. The directed cases
// cover saturation, floor rounding of negative products, the decoding of
// dimension values and a stalled result channel. They are followed by
// random traffic under a range of dimension settings.
// ----------------------------------------------------------------------------
module tb_top;

    import smm_pkg::*;

    localparam int DIM = 4;
    localparam int DIM_CAP = (DIM < IDX_CAP) ? DIM : IDX_CAP;
    // func code that the block takes and drops without a result
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    // cycles allowed for a load still in flight inside the block
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_ITEMS = 150;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    smm_in_t    item;
    logic       result_valid;
    logic       result_ready;
    smm_out_t   result;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;

    // Mirror of the block's state: both matrices, which entries have been
    // loaded since reset, and the three dimension registers as written
    int         mat_a [DIM*DIM];
    int         mat_b [DIM*DIM];
    bit         a_loaded [DIM*DIM];
    bit         b_loaded [DIM*DIM];
    logic [2:0] rows_cfg = 3'd4;
    logic [2:0] inner_cfg = 3'd4;
    logic [2:0] cols_cfg = 3'd4;

    // Elements of C still owed by the block, oldest first
    smm_out_t   pending_elems [$];

    int error_count = 0;
    int items_sent = 0;
    int computes_sent = 0;
    int elems_checked = 0;
    int settings_used = 0;
    int input_stalls = 0;
    // quiet: no idling on either side; hold_request: cycles of result hold-off
    bit quiet = 1'b0;
    int hold_request = 0;

    small_matrix_multiply uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAIL small_matrix_multiply");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Zero acts as one; anything above the index range acts as the top
    function automatic int clamp_dim(input logic [2:0] d);
        if (d == 3'd0)
            return 1;
        if (int'(d) > DIM_CAP)
            return DIM_CAP;
        return int'(d);
    endfunction

    // One element of C: exact products, each floored by 2^16, summed
    // wide and then saturated to 32 bits
    function automatic int product_element(input int i, input int j, input int nk);
        longint acc;
        longint term;
        acc = 0;
        for (int k = 0; k < nk; k++)
        begin
            term = longint'(mat_a[i*DIM + k]) * longint'(mat_b[k*DIM + j]);
            acc += term >>> 16;
        end
        if (acc > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (acc < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(acc);
    endfunction

    // Queue every element of C in row-major order, last one marked
    task automatic predict_product();
        smm_out_t e;
        int nr;
        int nk;
        int nc;
        nr = clamp_dim(rows_cfg);
        nk = clamp_dim(inner_cfg);
        nc = clamp_dim(cols_cfg);
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                e.out_row = 2'(i);
                e.out_col = 2'(j);
                e.out_value = product_element(i, j, nk);
                e.last = (i == nr - 1) && (j == nc - 1);
                pending_elems.push_back(e);
            end
        end
    endtask

    // Apply one accepted input transaction to the mirror
    task automatic track_item(input smm_in_t x);
        int at;
        at = int'(x.row_index) * DIM + int'(x.col_index);
        case (x.func)
            FUNC_LOAD_A:
            begin
                mat_a[at] = x.element_value;
                a_loaded[at] = 1'b1;
            end
            FUNC_LOAD_B:
            begin
                mat_b[at] = x.element_value;
                b_loaded[at] = 1'b1;
            end
            FUNC_COMPUTE:
            begin
                computes_sent++;
                predict_product();
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver behaviour
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        smm_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_elems.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result row %0d col %0d value %h last %b",
                         $time, result.out_row, result.out_col, result.out_value,
                         result.last);
            end
            else
            begin
                want = pending_elems.pop_front();
                elems_checked++;
                if (result !== want)
                begin
                    error_count++;
                    $display("%0t: expected row %0d col %0d value %h last %b",
                             $time, want.out_row, want.out_col, want.out_value, want.last);
                    $display("%0t:      got row %0d col %0d value %h last %b",
                             $time, result.out_row, result.out_col, result.out_value,
                             result.last);
                end
            end
        end
    end

    // Count cycles in which the block holds off an offered transaction
    always @(posedge clk)
    begin
        if (item_valid && !item_ready)
            input_stalls++;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int sender_gap();
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    // Drive result_ready: random stalls, none when quiet, and a long
    // hold-off on request, counted here in cycles
    initial
    begin : receiver
        int stall_left;
        int held;
        stall_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
                result_ready <= 1'b0;
                repeat (held - 1) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 30)
            begin
                stall_left = idle_len() - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; each is entered and left at a falling edge
    // ------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, then mirror it
    task automatic send_op(input logic [1:0] f, input logic [1:0] r,
                           input logic [1:0] c, input logic [31:0] v);
        smm_in_t x;
        int gap;
        x.func = f;
        x.row_index = r;
        x.col_index = c;
        x.element_value = v;
        gap = sender_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= x;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        track_item(x);
        if (f != FUNC_SPARE)
            items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every owed element, then let loads settle
    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_elems.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write: setup cycle, access cycle until pready, then psel drops and the bus idles
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        logic [31:0] data;
        data = $urandom;
        if ($urandom_range(0, 1) == 0)
            data[31:3] = '0;
        data[2:0] = val;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ROWS:  rows_cfg = val;
            REG_INNER: inner_cfg = val;
            REG_COLS:  cols_cfg = val;
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // Change dimensions only once the block has gone idle
    task automatic set_dims(input logic [2:0] r, input logic [2:0] k, input logic [2:0] c);
        drain_results();
        write_reg(REG_ROWS, r);
        write_reg(REG_INNER, k);
        write_reg(REG_COLS, c);
        settings_used++;
    endtask

    function automatic logic [31:0] pick_value();
        int mag;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            // within about +/-4.0, so sums mostly stay in range
            mag = $urandom_range(0, 32'h0004_0000);
            return ($urandom_range(0, 1) != 0) ? -mag : mag;
        end
        if (sel < 80)
            return $urandom;
        case ($urandom_range(0, 6))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0001_0000;
            4:       return 32'hFFFF_0000;
            5:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Load every entry the next compute will read that is still unwritten
    task automatic load_missing(output int sent);
        int nr;
        int nk;
        int nc;
        sent = 0;
        nr = clamp_dim(rows_cfg);
        nk = clamp_dim(inner_cfg);
        nc = clamp_dim(cols_cfg);
        for (int i = 0; i < nr; i++)
            for (int k = 0; k < nk; k++)
                if (!a_loaded[i*DIM + k])
                begin
                    send_op(FUNC_LOAD_A, 2'(i), 2'(k), pick_value());
                    sent++;
                end
        for (int k = 0; k < nk; k++)
            for (int j = 0; j < nc; j++)
                if (!b_loaded[k*DIM + j])
                begin
                    send_op(FUNC_LOAD_B, 2'(k), 2'(j), pick_value());
                    sent++;
                end
    endtask

    // Random load, mostly into the part of A or B that is in use
    task automatic send_random_load();
        logic [1:0] f;
        int rlim;
        int clim;
        f = ($urandom_range(0, 1) != 0) ? FUNC_LOAD_B : FUNC_LOAD_A;
        rlim = DIM_CAP;
        clim = DIM_CAP;
        if ($urandom_range(0, 9) < 7)
        begin
            rlim = (f == FUNC_LOAD_A) ? clamp_dim(rows_cfg) : clamp_dim(inner_cfg);
            clim = (f == FUNC_LOAD_A) ? clamp_dim(inner_cfg) : clamp_dim(cols_cfg);
        end
        send_op(f, 2'($urandom_range(0, rlim - 1)), 2'($urandom_range(0, clim - 1)),
                pick_value());
    endtask

    function automatic logic [2:0] random_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return 3'd0;
        if (sel < 22)
            return 3'($urandom_range(5, 7));
        return 3'($urandom_range(1, 4));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 1 x 1 x 1: saturation both ways, floor of a negative product,
    // and a spare func code that must vanish
    task automatic test_single_element();
        set_dims(3'd1, 3'd1, 3'd1);
        send_op(FUNC_LOAD_A, 2'd0, 2'd0, 32'h7FFF_FFFF);
        send_op(FUNC_LOAD_B, 2'd0, 2'd0, 32'h7FFF_FFFF);
        send_op(FUNC_COMPUTE, 2'd0, 2'd0, 32'h0000_0000);
        send_op(FUNC_LOAD_B, 2'd0, 2'd0, 32'h8000_0000);
        send_op(FUNC_COMPUTE, 2'd3, 2'd3, 32'hFFFF_FFFF);
        send_op(FUNC_LOAD_A, 2'd0, 2'd0, 32'h8000_0000);
        send_op(FUNC_COMPUTE, 2'd0, 2'd0, 32'h0000_0000);
        // -1 x 1 is a tiny negative product: floors to -1, not 0
        send_op(FUNC_LOAD_A, 2'd0, 2'd0, 32'hFFFF_FFFF);
        send_op(FUNC_LOAD_B, 2'd0, 2'd0, 32'h0000_0001);
        send_op(FUNC_COMPUTE, 2'd0, 2'd0, 32'h0000_0000);
        send_op(FUNC_SPARE, 2'd3, 2'd3, 32'hA5A5_5A5A);
    endtask

    // Zero dimensions act as one; then a hand-picked 2 x 2 product with
    // the far corner loaded but outside the active area
    task automatic test_dimension_decode();
        set_dims(3'd0, 3'd0, 3'd0);
        send_op(FUNC_COMPUTE, 2'd0, 2'd0, 32'h0000_0000);
        send_op(FUNC_LOAD_A, 2'd3, 2'd3, 32'h7FFF_FFFF);
        send_op(FUNC_LOAD_B, 2'd3, 2'd3, 32'h8000_0000);
        set_dims(3'd2, 3'd2, 3'd2);
        send_op(FUNC_LOAD_A, 2'd0, 2'd0, 32'h0001_0000);
        send_op(FUNC_LOAD_A, 2'd0, 2'd1, 32'h0002_8000);
        send_op(FUNC_LOAD_A, 2'd1, 2'd0, 32'hFFFF_0000);
        send_op(FUNC_LOAD_A, 2'd1, 2'd1, 32'h0000_4000);
        send_op(FUNC_LOAD_B, 2'd0, 2'd0, 32'h0003_0000);
        send_op(FUNC_LOAD_B, 2'd0, 2'd1, 32'hFFFE_8000);
        send_op(FUNC_LOAD_B, 2'd1, 2'd0, 32'h7FFF_FFFF);
        send_op(FUNC_LOAD_B, 2'd1, 2'd1, 32'h0000_0001);
        send_op(FUNC_COMPUTE, 2'd0, 2'd0, 32'h0000_0000);
    endtask

    // Full size, rows and cols via out-of-range register values; hold the result side
    // off for a long stretch while computes and loads keep coming, so the
    // block backs up onto its input
    task automatic test_backpressure();
        int sent;
        quiet = 1'b1;
        set_dims(3'd7, 3'd4, 3'd5);
        load_missing(sent);
        quiet = 1'b0;
        hold_request = LONG_HOLD;
        for (int n = 0; n < 3; n++)
        begin
            send_op(FUNC_COMPUTE, 2'($urandom), 2'($urandom), $urandom);
            send_random_load();
            send_random_load();
        end
        drain_results();
    endtask

    // Phases of random traffic, each under fresh dimensions; computes are
    // preceded by whatever loads the contract requires
    task automatic test_random_traffic();
        int made;
        int sent;
        int phase_len;
        int sel;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            set_dims(random_dim(), random_dim(), random_dim());
            phase_len = $urandom_range(6, 18);
            for (int n = 0; n < phase_len; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                begin
                    send_op(FUNC_SPARE, 2'($urandom), 2'($urandom), $urandom);
                end
                else if (sel < 30)
                begin
                    load_missing(sent);
                    send_op(FUNC_COMPUTE, 2'($urandom), 2'($urandom), $urandom);
                    made += sent + 1;
                end
                else
                begin
                    send_random_load();
                    made++;
                end
                // now and then pause the sender until the block has caught up
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        test_single_element();
        test_dimension_decode();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (20) @(negedge clk);

        $display("Covered %0d load and compute transactions (%0d computes) over %0d settings",
                 items_sent, computes_sent, settings_used);
        $display("Checked %0d result elements; input held off for %0d cycles",
                 elems_checked, input_stalls);
        if (error_count == 0)
            $display("PASS small_matrix_multiply");
        else
            $display("FAIL small_matrix_multiply");
        $finish;
    end

endmodule
